// ===== rtl/core/ole_pkg.sv =====
// ============================================================================
// ole_pkg - shared types for the ordered list engine
// Operation kinds, result status codes, controller states and the
// command/status bundles between the controller and the datapath.
// ============================================================================
package ole_pkg;

    typedef enum logic [2:0] {
        KIND_INSERT = 3'd0,
        KIND_MEMBER = 3'd1,
        KIND_COUNT  = 3'd2,
        KIND_REMOVE = 3'd3,
        KIND_TRUNC  = 3'd4,
        KIND_POP    = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT,
        S_POP_RD,
        S_POP_CAP,
        S_COMPACT,
        S_DONE
    } t_state;

    // memory walk performed by the datapath in the current cycle
    typedef enum logic [1:0] {
        PH_NONE,
        PH_SCAN,
        PH_SHIFT,
        PH_COMPACT
    } t_phase;

    typedef struct packed {
        logic    load;         // capture input beat
        logic    scan_init;    // start equality scan
        logic    shift_init;   // start insert shift-up
        logic    cmp_init_rm;  // start compaction, drop last match
        logic    pop_rd;       // read last entry
        logic    pop_cap;      // capture popped entry, start compaction
        t_phase  phase;
        logic    ins_write;    // write new entry at position, length + 1
        logic    truncate;     // length <= first match index
        logic    commit;       // length <= compaction write pointer
        logic    set_status;
        t_status status;
        logic    out_load;     // move result into output register
    } t_dp_cmd;

    typedef struct packed {
        logic       walk_done;
        logic       len_full;
        logic       len_zero;
        logic       cnt_zero;
        logic [2:0] kind;
        logic       out_busy;
    } t_dp_stat;

endpackage

// ===== rtl/core/ole_ctrl.sv =====
// ============================================================================
// ole_ctrl - operation sequencer
// Steps one operation at a time through scan, shift and compaction walks.
// ============================================================================
module ole_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ole_pkg::t_dp_stat i_stat,
    output ole_pkg::t_dp_cmd  o_cmd
);
    import ole_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.phase  = PH_NONE;
        o_cmd.status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.kind) inside
                    KIND_INSERT: begin
                        if (i_stat.len_full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                            n_state          = S_DONE;
                        end else begin
                            o_cmd.shift_init = 1'b1;
                            n_state          = S_SHIFT;
                        end
                    end
                    KIND_MEMBER, KIND_COUNT, KIND_REMOVE, KIND_TRUNC: begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                    KIND_POP: begin
                        if (i_stat.len_zero) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EMPTY;
                            n_state          = S_DONE;
                        end else begin
                            n_state = S_POP_RD;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                o_cmd.phase = PH_SCAN;
                if (i_stat.walk_done) begin
                    n_state = S_DONE;
                    if (i_stat.cnt_zero) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_NOT_FOUND;
                    end else if (i_stat.kind == KIND_REMOVE) begin
                        o_cmd.cmp_init_rm = 1'b1;
                        n_state           = S_COMPACT;
                    end else if (i_stat.kind == KIND_TRUNC) begin
                        o_cmd.truncate = 1'b1;
                    end
                end
            end
            S_SHIFT: begin
                o_cmd.phase = PH_SHIFT;
                if (i_stat.walk_done) begin
                    o_cmd.ins_write = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_POP_RD: begin
                o_cmd.pop_rd = 1'b1;
                n_state      = S_POP_CAP;
            end
            S_POP_CAP: begin
                o_cmd.pop_cap = 1'b1;
                n_state       = S_COMPACT;
            end
            S_COMPACT: begin
                o_cmd.phase = PH_COMPACT;
                if (i_stat.walk_done) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/ole_dpath.sv =====
// ============================================================================
// ole_dpath - list storage and walk datapath
// Entry memory with one write and one registered read port, walk counters,
// match counting and the output register.
// ============================================================================
module ole_dpath #(
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ole_pkg::t_dp_cmd       i_cmd,
    output ole_pkg::t_dp_stat      o_stat,
    input  logic [2:0]             i_kind,
    input  logic [VALUE_BITS-1:0]  i_value,
    input  logic signed [9:0]      i_position,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output ole_pkg::t_status       o_status,
    output logic                   o_found,
    output logic [8:0]             o_match_count,
    output logic [63:0]            o_popped,
    output logic [8:0]             o_length
);
    import ole_pkg::*;

    localparam int LW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int PW = (LW > 9) ? LW : 9;

    logic [VALUE_BITS-1:0] r_mem [DEPTH];
    logic [VALUE_BITS-1:0] r_rdata;

    logic [LW-1:0]         r_len;
    logic [2:0]            r_kind;
    logic [VALUE_BITS-1:0] r_val;
    logic [LW-1:0]         r_pos;
    logic [LW-1:0]         r_ra;
    logic [LW-1:0]         r_pi;
    logic                  r_pv;
    logic [LW-1:0]         r_wp;
    logic [LW-1:0]         r_lim;
    logic                  r_mode_pop;
    logic [LW-1:0]         r_cnt;
    logic [LW-1:0]         r_first;
    logic [LW-1:0]         r_last;
    logic                  r_hit;
    logic [VALUE_BITS-1:0] r_popped;
    t_status               r_status;
    logic                  r_ovalid;

    logic                  issue;
    logic [LW-1:0]         n_ra;
    logic [LW-1:0]         ra_m1;
    logic [LW-1:0]         len_m1;
    logic [LW-1:0]         pi_p1;
    logic [IW-1:0]         rd_addr;
    logic                  rd_en;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic                  match;
    logic                  discard;
    logic [PW-1:0]         pos_ext;
    logic [LW-1:0]         pos_clamp;

    assign ra_m1   = r_ra - LW'(1);
    assign len_m1  = r_len - LW'(1);
    assign pi_p1   = r_pi + LW'(1);
    assign match   = (r_rdata == r_val);
    assign discard = r_mode_pop ? (r_rdata == r_popped) : (r_pi == r_last);

    // negative positions clamp to the head, large ones to the tail
    assign pos_ext   = PW'(i_position[8:0]);
    assign pos_clamp = i_position[9]           ? '0    :
                       (pos_ext > PW'(r_len))   ? r_len : LW'(pos_ext);

    // read side of the walk
    always_comb begin
        issue   = 1'b0;
        n_ra    = r_ra + LW'(1);
        rd_addr = r_ra[IW-1:0];
        case (i_cmd.phase)
            PH_SCAN:    issue = (r_ra < r_len);
            PH_COMPACT: issue = (r_ra < r_lim);
            PH_SHIFT: begin
                issue   = (r_ra > r_pos);
                n_ra    = ra_m1;
                rd_addr = ra_m1[IW-1:0];
            end
            default: issue = 1'b0;
        endcase
        if (i_cmd.pop_rd) begin
            rd_addr = len_m1[IW-1:0];
        end
        rd_en = issue | i_cmd.pop_rd;
    end

    // write side: shifted entry, kept entry, or the inserted value
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_wp[IW-1:0];
        wr_data = r_rdata;
        if (i_cmd.ins_write) begin
            wr_en   = 1'b1;
            wr_addr = r_pos[IW-1:0];
            wr_data = r_val;
        end else if (r_pv && i_cmd.phase == PH_SHIFT) begin
            wr_en   = 1'b1;
            wr_addr = pi_p1[IW-1:0];
        end else if (r_pv && i_cmd.phase == PH_COMPACT && !discard) begin
            wr_en   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_pv <= issue;
            if (i_cmd.ins_write) begin
                r_len <= r_len + LW'(1);
            end else if (i_cmd.truncate) begin
                r_len <= r_first;
            end else if (i_cmd.commit) begin
                r_len <= r_wp;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // item and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_val    <= i_value;
            r_pos    <= pos_clamp;
            r_cnt    <= '0;
            r_popped <= '0;
            r_status <= ST_OK;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.scan_init) begin
            r_ra  <= '0;
            r_cnt <= '0;
            r_hit <= 1'b0;
        end else if (i_cmd.shift_init) begin
            r_ra <= r_len;
        end else if (i_cmd.cmp_init_rm) begin
            r_ra       <= '0;
            r_wp       <= '0;
            r_lim      <= r_len;
            r_mode_pop <= 1'b0;
        end else if (i_cmd.pop_cap) begin
            r_popped   <= r_rdata;
            r_cnt      <= LW'(1);
            r_ra       <= '0;
            r_wp       <= '0;
            r_lim      <= len_m1;
            r_mode_pop <= 1'b1;
        end else begin
            if (issue) begin
                r_ra <= n_ra;
                r_pi <= (i_cmd.phase == PH_SHIFT) ? ra_m1 : r_ra;
            end
            if (r_pv && i_cmd.phase == PH_SCAN && match) begin
                r_cnt  <= r_cnt + LW'(1);
                r_last <= r_pi;
                if (!r_hit) begin
                    r_first <= r_pi;
                    r_hit   <= 1'b1;
                end
            end
            if (r_pv && i_cmd.phase == PH_COMPACT) begin
                if (!discard) begin
                    r_wp <= r_wp + LW'(1);
                end else if (r_mode_pop) begin
                    r_cnt <= r_cnt + LW'(1);
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status      <= r_status;
            o_found       <= (r_cnt != '0);
            o_match_count <= 9'(r_cnt);
            o_popped      <= 64'(r_popped);
            o_length      <= 9'(r_len);
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_stat.walk_done = !issue && !r_pv;
    assign o_stat.len_full  = (r_len >= LW'(DEPTH));
    assign o_stat.len_zero  = (r_len == '0);
    assign o_stat.cnt_zero  = (r_cnt == '0);
    assign o_stat.kind      = r_kind;
    assign o_stat.out_busy  = r_ovalid && !i_out_ready;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(DEPTH))
        else $error("list length above depth");

    a_wp_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv && i_cmd.phase == PH_COMPACT) |-> (r_wp <= r_pi))
        else $error("compaction write pointer passed read index");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv && i_cmd.phase == PH_SHIFT) |-> (r_pi >= r_pos && r_pi < r_len))
        else $error("shift read outside position..length");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_ovalid || i_out_ready))
        else $error("result loaded over an untaken result");

endmodule

// ===== rtl/core/ordered_list_engine.sv =====
// ============================================================================
// ordered_list_engine - ordered list with insert, search and delete
// Top level: stream ports, sequencer and list datapath.
// ============================================================================
// Keeps an ordered list of up to DEPTH entries of VALUE_BITS bits in a
// single memory with one write and one registered read port, and serves one
// operation per input beat with exactly one result beat. Operations are
// selected by s_axis_tuser: insert at a clamped position, member test,
// count, remove last match, truncate at first match, and pop-dups. A full
// list rejects an insert (status full), popping an empty list reports
// status empty, and a search that finds nothing reports status not found
// with the list left as is. One operation is in flight at a time; a new
// beat is taken as soon as the previous operation has moved its result to
// the output register, even if that result is still waiting on
// m_axis_tready. The memory walk, one entry a cycle through the single
// read port, sets the time an operation takes: insert shifts the entries
// from the tail down to the position, member/count/truncate scan the
// list, remove scans and then compacts it, and pop-dups reads the last
// entry and then compacts the rest. The entry memory needs no clearing
// after reset.
// ============================================================================
module ordered_list_engine #(
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // value[63:0], position[73:64], zero
    input  logic [2:0]  s_axis_tuser,   // kind[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata    // status[1:0], found[2],
                                        // match_count[11:3], popped[75:12],
                                        // length[84:76], zero
);
    import ole_pkg::*;

    t_dp_cmd    cmd;
    t_dp_stat   stat;
    t_status    res_status;
    logic       res_found;
    logic [8:0] res_count;
    logic [63:0] res_popped;
    logic [8:0] res_length;

    ole_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ole_dpath #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_kind        (s_axis_tuser),
        .i_value       (s_axis_tdata[VALUE_BITS-1:0]),  // low bits only
        .i_position    (s_axis_tdata[73:64]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (res_status),
        .o_found       (res_found),
        .o_match_count (res_count),
        .o_popped      (res_popped),
        .o_length      (res_length)
    );

    // result beat packing, highest field first, status in the lowest bits
    assign m_axis_tdata = {3'b000, res_length, res_popped, res_count,
                           res_found, res_status};

endmodule
